// ----- src/chte_pkg.sv -----
// ----------------------------------------------------------------------------
// chte_pkg
// Shared constants for the chained hash table engine: parameter defaults,
// fixed field widths, action and status codes.
// ----------------------------------------------------------------------------
package chte_pkg;

  localparam int BUCKETS_DEF    = 256;
  localparam int NODES_DEF      = 1024;
  localparam int VALUE_BITS_DEF = 64;

  localparam int ACT_W    = 3;
  localparam int KEY_W    = 64;
  localparam int VAL_W    = 64;
  localparam int NB_W     = 9;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  localparam logic [ACT_W-1:0] ACT_INS_KEEP   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_REP    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FIND       = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DEL        = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DEL_ALL    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_RESIZE     = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SCAN_FIRST = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SCAN_NEXT  = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOTF = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // number of key bits the shared modulo unit retires per cycle
  localparam int MOD_STEP = 4;

endpackage

// ----- src/chained_hash_table_engine.sv -----
// ----------------------------------------------------------------------------
// chained_hash_table_engine
// Key-value store with separate chaining over a fixed node pool.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one word per action: action,
//   key, value_in, new_buckets. Output channel (out_valid/out_stall) returns
//   exactly one word per action: status, key_out, value_out, entry_count,
//   buckets_in_use. A word moves when valid is high and stall is low.
//   One action is worked at a time; in_stall is high until it finishes.
//   Keyed actions run the shared modulo unit (4 key bits per cycle), one
//   head read, then one read per chain node visited, then the link
//   updates. Scans read one chain node per result and skip empty
//   buckets. Delete all clears the bucket heads. Resize walks all nodes,
//   clears the heads, then relinks each node through the modulo unit.
//   Reset: a clearing pass empties the bucket heads; in_stall stays high
//   during it.
//   A stalled result holds in the output register; the next action may be
//   accepted meanwhile but cannot finish until that result is taken.
// ----------------------------------------------------------------------------
module chained_hash_table_engine #(
  parameter int BUCKETS    = chte_pkg::BUCKETS_DEF,
  parameter int NODES      = chte_pkg::NODES_DEF,
  parameter int VALUE_BITS = chte_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [chte_pkg::ACT_W-1:0]          action,
  input  logic signed [chte_pkg::KEY_W-1:0]   key,
  input  logic [chte_pkg::VAL_W-1:0]          value_in,
  input  logic [chte_pkg::NB_W-1:0]           new_buckets,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [chte_pkg::STATUS_W-1:0]       status,
  output logic signed [chte_pkg::KEY_W-1:0]   key_out,
  output logic [chte_pkg::VAL_W-1:0]          value_out,
  output logic [chte_pkg::COUNT_W-1:0]        entry_count,
  output logic [chte_pkg::NB_W-1:0]           buckets_in_use
);

  import chte_pkg::*;

  // widths: node pointer holds NODES as the null link
  localparam int PW   = $clog2(NODES + 1);
  localparam int NW   = $clog2(NODES);
  localparam int BW   = $clog2(BUCKETS + 1);
  localparam int BIW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NBW  = (BW > NB_W) ? BW : NB_W;
  localparam int MODN = KEY_W / MOD_STEP;
  localparam int MCW  = $clog2(MODN);

  localparam logic [PW-1:0] NIL   = PW'(NODES);
  localparam logic [BW-1:0] BLAST = BW'(BUCKETS - 1);

  // sequencer states
  localparam logic [4:0] S_CLR      = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_MOD      = 5'd2;
  localparam logic [4:0] S_HEAD     = 5'd3;
  localparam logic [4:0] S_HEADW    = 5'd4;
  localparam logic [4:0] S_WALK     = 5'd5;
  localparam logic [4:0] S_WALKW    = 5'd6;
  localparam logic [4:0] S_ALLOC    = 5'd7;
  localparam logic [4:0] S_ALLOCW   = 5'd8;
  localparam logic [4:0] S_INS1     = 5'd9;
  localparam logic [4:0] S_INS2     = 5'd10;
  localparam logic [4:0] S_DEL1     = 5'd11;
  localparam logic [4:0] S_DEL2     = 5'd12;
  localparam logic [4:0] S_RS_HEAD  = 5'd13;
  localparam logic [4:0] S_RS_HEADW = 5'd14;
  localparam logic [4:0] S_RS_WALK  = 5'd15;
  localparam logic [4:0] S_RS_LINKW = 5'd16;
  localparam logic [4:0] S_RH_ORD   = 5'd17;
  localparam logic [4:0] S_RH_ORDW  = 5'd18;
  localparam logic [4:0] S_RH_KEYW  = 5'd19;
  localparam logic [4:0] S_RH_HEAD  = 5'd20;
  localparam logic [4:0] S_RH_HEADW = 5'd21;
  localparam logic [4:0] S_RH_LINK  = 5'd22;
  localparam logic [4:0] S_SC0      = 5'd23;
  localparam logic [4:0] S_SC0W     = 5'd24;
  localparam logic [4:0] S_SCAN     = 5'd25;
  localparam logic [4:0] S_SC_HW    = 5'd26;
  localparam logic [4:0] S_SC_HITW  = 5'd27;
  localparam logic [4:0] S_DONE     = 5'd28;

  // where the clearing pass and the modulo unit hand back to
  localparam logic [1:0] RET_IDLE = 2'd0;
  localparam logic [1:0] RET_DALL = 2'd1;
  localparam logic [1:0] RET_RH   = 2'd2;
  localparam logic       MR_LOC   = 1'b0;
  localparam logic       MR_RH    = 1'b1;

  // memories
  logic [PW-1:0]         head_mem [BUCKETS];
  logic [PW-1:0]         tail_mem [BUCKETS];
  logic [KEY_W-1:0]      key_mem  [NODES];
  logic [VALUE_BITS-1:0] val_mem  [NODES];
  logic [PW-1:0]         link_mem [NODES];
  logic [NW-1:0]         ord_mem  [NODES];

  logic            head_we, tail_we, key_we, val_we, link_we, ord_we;
  logic [BIW-1:0]  head_addr, tail_addr;
  logic [NW-1:0]   key_addr, val_addr, link_addr, ord_addr;
  logic [PW-1:0]   head_wd, tail_wd, link_wd;
  logic [NW-1:0]   ord_wd;
  logic [PW-1:0]   head_rd, tail_rd, link_rd;
  logic [KEY_W-1:0]      key_rd;
  logic [VALUE_BITS-1:0] val_rd;
  logic [NW-1:0]   ord_rd;

  // control state
  logic [4:0]      state;
  logic [1:0]      clr_ret;
  logic            mod_ret;
  logic [BW-1:0]   clr_idx;
  logic [MCW-1:0]  mod_cnt;
  logic [BW-1:0]   rem;
  logic [PW-1:0]   free_head, fresh, stored_count;
  logic [BW-1:0]   bucket_total, scan_bucket, rb;
  logic [PW-1:0]   scan_node;
  logic [PW-1:0]   p, prev, succ;
  logic [PW-1:0]   cnt, idx;

  // payload registers
  logic [ACT_W-1:0]      act;
  logic [KEY_W-1:0]      key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [BW-1:0]         nb_r;
  logic [KEY_W-1:0]      modx;
  logic [STATUS_W-1:0]   res_status;
  logic [KEY_W-1:0]      res_key;
  logic [VALUE_BITS-1:0] res_val;
  logic [STATUS_W-1:0]   o_status;
  logic [KEY_W-1:0]      o_key;
  logic [VALUE_BITS-1:0] o_val;
  logic [COUNT_W-1:0]    o_count;
  logic [NB_W-1:0]       o_buckets;

  logic            in_take;
  logic [BW-1:0]   rem_step;
  logic [BW-1:0]   nb_clamp;
  logic [BW:0]     sb_inc, rb_inc;
  logic            pool_full;

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign pool_full = (free_head == NIL) && (fresh == NIL);
  assign sb_inc    = {1'b0, scan_bucket} + 1'b1;
  assign rb_inc    = {1'b0, rb} + 1'b1;

  // resize count clamped to 1..BUCKETS
  always_comb begin
    logic [NBW-1:0] nbx;
    nbx = NBW'(new_buckets);
    if (nbx == '0) begin
      nb_clamp = BW'(1);
    end else if (nbx > NBW'(BUCKETS)) begin
      nb_clamp = BW'(BUCKETS);
    end else begin
      nb_clamp = BW'(nbx);
    end
  end

  // shared modulo unit: restoring steps, MOD_STEP key bits per cycle
  always_comb begin
    logic [BW:0] t;
    rem_step = rem;
    for (int j = 0; j < MOD_STEP; j++) begin
      t = {rem_step, modx[KEY_W-1-j]};
      if (t >= {1'b0, bucket_total}) begin
        t = t - {1'b0, bucket_total};
      end
      rem_step = t[BW-1:0];
    end
  end

  // memory port control
  always_comb begin
    head_we   = 1'b0;
    tail_we   = 1'b0;
    key_we    = 1'b0;
    val_we    = 1'b0;
    link_we   = 1'b0;
    ord_we    = 1'b0;
    head_addr = rem[BIW-1:0];
    tail_addr = rem[BIW-1:0];
    key_addr  = p[NW-1:0];
    val_addr  = p[NW-1:0];
    link_addr = p[NW-1:0];
    ord_addr  = idx[NW-1:0];
    head_wd   = p;
    tail_wd   = p;
    link_wd   = NIL;
    ord_wd    = p[NW-1:0];
    case (state)
      S_CLR: begin
        head_we   = 1'b1;
        head_addr = clr_idx[BIW-1:0];
        head_wd   = NIL;
      end
      S_WALKW: begin
        if (key_rd == key_r && act == ACT_INS_REP) begin
          val_we = 1'b1;
        end
      end
      S_ALLOC: begin
        link_addr = free_head[NW-1:0];
      end
      S_INS1: begin
        key_we  = 1'b1;
        val_we  = 1'b1;
        link_we = 1'b1;
        link_wd = NIL;
      end
      S_INS2: begin
        if (prev == NIL) begin
          head_we = 1'b1;
        end else begin
          link_we   = 1'b1;
          link_addr = prev[NW-1:0];
          link_wd   = p;
        end
      end
      S_DEL1: begin
        link_we = 1'b1;
        link_wd = free_head;
      end
      S_DEL2: begin
        if (prev == NIL) begin
          head_we = 1'b1;
          head_wd = succ;
        end else begin
          link_we   = 1'b1;
          link_addr = prev[NW-1:0];
          link_wd   = succ;
        end
      end
      S_RS_HEAD: begin
        head_addr = rb[BIW-1:0];
      end
      S_RS_WALK: begin
        ord_addr = cnt[NW-1:0];
        ord_we   = (p != NIL) && (cnt != NIL);
      end
      S_RH_ORDW: begin
        key_addr = ord_rd;
      end
      S_RH_HEADW: begin
        link_we = 1'b1;
        link_wd = NIL;
        tail_we = 1'b1;
        head_we = (head_rd == NIL);
      end
      S_RH_LINK: begin
        link_we   = 1'b1;
        link_addr = succ[NW-1:0];
        link_wd   = p;
      end
      S_SC0: begin
        head_addr = '0;
      end
      S_SCAN: begin
        key_addr  = scan_node[NW-1:0];
        val_addr  = scan_node[NW-1:0];
        link_addr = scan_node[NW-1:0];
        head_addr = sb_inc[BIW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_addr] <= head_wd;
    head_rd <= head_mem[head_addr];
  end

  always_ff @(posedge clk) begin
    if (tail_we) tail_mem[tail_addr] <= tail_wd;
    tail_rd <= tail_mem[tail_addr];
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_addr] <= key_r;
    key_rd <= key_mem[key_addr];
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_addr] <= val_r;
    val_rd <= val_mem[val_addr];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_addr] <= link_wd;
    link_rd <= link_mem[link_addr];
  end

  always_ff @(posedge clk) begin
    if (ord_we) ord_mem[ord_addr] <= ord_wd;
    ord_rd <= ord_mem[ord_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr_ret      <= RET_IDLE;
      clr_idx      <= '0;
      mod_ret      <= MR_LOC;
      mod_cnt      <= '0;
      free_head    <= NIL;
      fresh        <= '0;
      stored_count <= '0;
      bucket_total <= BW'(BUCKETS);
      scan_bucket  <= '0;
      scan_node    <= NIL;
      rb           <= '0;
      cnt          <= '0;
      idx          <= '0;
      p            <= NIL;
      prev         <= NIL;
      succ         <= NIL;
      out_valid    <= 1'b0;
    end else begin
      // result word: raised as it is released, dropped once taken
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          if (clr_idx == BLAST) begin
            clr_idx <= '0;
            case (clr_ret)
              RET_DALL: state <= S_DONE;
              RET_RH: begin
                idx   <= '0;
                state <= S_RH_ORD;
              end
              default: state <= S_IDLE;
            endcase
          end else begin
            clr_idx <= clr_idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_take) begin
            act        <= action;
            key_r      <= key;
            val_r      <= value_in[VALUE_BITS-1:0];
            nb_r       <= nb_clamp;
            res_status <= ST_OK;
            res_key    <= '0;
            res_val    <= '0;
            case (action)
              ACT_DEL_ALL: begin
                free_head    <= NIL;
                fresh        <= '0;
                stored_count <= '0;
                scan_bucket  <= bucket_total;
                scan_node    <= NIL;
                clr_idx      <= '0;
                clr_ret      <= RET_DALL;
                state        <= S_CLR;
              end
              ACT_RESIZE: begin
                rb    <= '0;
                cnt   <= '0;
                state <= S_RS_HEAD;
              end
              ACT_SCAN_FIRST: state <= S_SC0;
              ACT_SCAN_NEXT:  state <= S_SCAN;
              default: begin
                modx    <= key;
                rem     <= '0;
                mod_cnt <= '0;
                mod_ret <= MR_LOC;
                state   <= S_MOD;
              end
            endcase
          end
        end
        S_MOD: begin
          rem     <= rem_step;
          modx    <= modx << MOD_STEP;
          mod_cnt <= mod_cnt + 1'b1;
          if (mod_cnt == MCW'(MODN - 1)) begin
            state <= (mod_ret == MR_RH) ? S_RH_HEAD : S_HEAD;
          end
        end
        S_HEAD: state <= S_HEADW;
        S_HEADW: begin
          p     <= head_rd;
          prev  <= NIL;
          state <= S_WALK;
        end
        S_WALK: begin
          if (p == NIL) begin
            case (act)
              ACT_INS_KEEP, ACT_INS_REP: begin
                if (pool_full) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  state <= S_ALLOC;
                end
              end
              default: begin
                res_status <= ST_NOTF;
                state      <= S_DONE;
              end
            endcase
          end else begin
            state <= S_WALKW;
          end
        end
        S_WALKW: begin
          if (key_rd == key_r) begin
            succ    <= link_rd;
            res_key <= key_r;
            res_val <= (act == ACT_INS_REP) ? val_r : val_rd;
            state   <= (act == ACT_DEL) ? S_DEL1 : S_DONE;
          end else begin
            prev  <= p;
            p     <= link_rd;
            state <= S_WALK;
          end
        end
        S_ALLOC: begin
          if (free_head != NIL) begin
            p     <= free_head;
            state <= S_ALLOCW;
          end else begin
            p     <= fresh;
            fresh <= fresh + 1'b1;
            state <= S_INS1;
          end
        end
        S_ALLOCW: begin
          free_head <= link_rd;
          state     <= S_INS1;
        end
        S_INS1: begin
          stored_count <= stored_count + 1'b1;
          res_key      <= key_r;
          res_val      <= val_r;
          state        <= S_INS2;
        end
        S_INS2: state <= S_DONE;
        S_DEL1: begin
          free_head <= p;
          if (scan_node == p) begin
            scan_node <= succ;
          end
          if (stored_count != '0) begin
            stored_count <= stored_count - 1'b1;
          end
          state <= S_DEL2;
        end
        S_DEL2: state <= S_DONE;
        // resize, pass 1: record every node in scan order
        S_RS_HEAD: state <= S_RS_HEADW;
        S_RS_HEADW: begin
          p     <= head_rd;
          state <= S_RS_WALK;
        end
        S_RS_WALK: begin
          if (p == NIL) begin
            if (rb_inc == {1'b0, bucket_total}) begin
              bucket_total <= nb_r;
              clr_idx      <= '0;
              clr_ret      <= RET_RH;
              state        <= S_CLR;
            end else begin
              rb    <= rb_inc[BW-1:0];
              state <= S_RS_HEAD;
            end
          end else begin
            if (cnt != NIL) begin
              cnt <= cnt + 1'b1;
            end
            state <= S_RS_LINKW;
          end
        end
        S_RS_LINKW: begin
          p     <= link_rd;
          state <= S_RS_WALK;
        end
        // resize, pass 2: append each recorded node to its new chain
        S_RH_ORD: begin
          if (idx == cnt) begin
            scan_bucket <= bucket_total;
            scan_node   <= NIL;
            state       <= S_DONE;
          end else begin
            state <= S_RH_ORDW;
          end
        end
        S_RH_ORDW: begin
          p     <= PW'(ord_rd);
          state <= S_RH_KEYW;
        end
        S_RH_KEYW: begin
          modx    <= key_rd;
          rem     <= '0;
          mod_cnt <= '0;
          mod_ret <= MR_RH;
          state   <= S_MOD;
        end
        S_RH_HEAD: state <= S_RH_HEADW;
        S_RH_HEADW: begin
          if (head_rd == NIL) begin
            idx   <= idx + 1'b1;
            state <= S_RH_ORD;
          end else begin
            succ  <= tail_rd;
            state <= S_RH_LINK;
          end
        end
        S_RH_LINK: begin
          idx   <= idx + 1'b1;
          state <= S_RH_ORD;
        end
        // scan
        S_SC0: state <= S_SC0W;
        S_SC0W: begin
          scan_bucket <= '0;
          scan_node   <= head_rd;
          state       <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_node != NIL) begin
            state <= S_SC_HITW;
          end else if (sb_inc < {1'b0, bucket_total}) begin
            scan_bucket <= sb_inc[BW-1:0];
            state       <= S_SC_HW;
          end else begin
            scan_bucket <= bucket_total;
            res_status  <= ST_NOTF;
            state       <= S_DONE;
          end
        end
        S_SC_HW: begin
          if (head_rd != NIL) begin
            scan_node <= head_rd;
          end
          state <= S_SCAN;
        end
        S_SC_HITW: begin
          scan_node <= link_rd;
          res_key   <= key_rd;
          res_val   <= val_rd;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register, loaded as the result word is released
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      o_status  <= res_status;
      o_key     <= res_key;
      o_val     <= res_val;
      o_count   <= COUNT_W'(stored_count);
      o_buckets <= NB_W'(bucket_total);
    end
  end

  assign status         = o_status;
  assign key_out        = o_key;
  assign value_out      = VAL_W'(o_val);
  assign entry_count    = o_count;
  assign buckets_in_use = o_buckets;

endmodule
